### hdl/grlu_pkg.sv
// Package for the grid ray log-odds update block.
// Holds the sizes, codes, payload words and arithmetic helpers; no dependencies.
`default_nettype none
package grlu_pkg;

  localparam int GRID_DIM_DEF  = 256;
  localparam int FRAC_BITS_DEF = 8;

  localparam int CELL_W   = 16;
  localparam int COUNT_W  = 10;
  localparam int COORD_W  = 18;
  localparam int DIST_W   = 40;
  localparam int STEP_W   = 32;
  localparam int MAG_W    = 16;
  localparam int COMP_W   = 17;
  localparam int CORD_W   = 20;
  localparam int ANG_W    = 18;
  localparam int CORD_ITER = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 20'sd19898;
  localparam logic signed [COMP_W-1:0] UNIT_POS = 17'sd32768;
  localparam logic signed [COMP_W-1:0] UNIT_NEG = -17'sd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREE_INC = 2'd0,
    CFG_OCC_INC  = 2'd1,
    CFG_EXTENT   = 2'd2,
    CFG_SPARE    = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    CMD_CAST = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CORDIC,
    S_PREP,
    S_DIV,
    S_MUL,
    S_WALK_RD,
    S_WALK_WR,
    S_FOOT_RD,
    S_FOOT_WR,
    S_READ_RD,
    S_READ_WAIT
  } state_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] heading;
    logic [15:0] ray_range;
    logic [7:0]  read_col;
    logic [7:0]  read_row;
  } in_word_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] cell_value;
    logic [COUNT_W-1:0]       cells_touched;
  } out_word_t;

  // CORDIC arctangent steps in binary-angle units
  function automatic logic [13:0] atan_step(input logic [3:0] i);
    logic [13:0] r;
    begin
      unique case (i)
        4'd0:  r = 14'd8192;
        4'd1:  r = 14'd4836;
        4'd2:  r = 14'd2555;
        4'd3:  r = 14'd1297;
        4'd4:  r = 14'd651;
        4'd5:  r = 14'd326;
        4'd6:  r = 14'd163;
        4'd7:  r = 14'd81;
        4'd8:  r = 14'd41;
        4'd9:  r = 14'd20;
        4'd10: r = 14'd10;
        4'd11: r = 14'd5;
        4'd12: r = 14'd3;
        4'd13: r = 14'd1;
        4'd14: r = 14'd1;
        default: r = 14'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [COMP_W-1:0] clamp_unit(input logic signed [CORD_W-1:0] v);
    logic signed [COMP_W-1:0] r;
    begin
      if (v > CORD_W'(UNIT_POS)) r = UNIT_POS;
      else if (v < CORD_W'(UNIT_NEG)) r = UNIT_NEG;
      else r = v[COMP_W-1:0];
      return r;
    end
  endfunction

  function automatic logic signed [CELL_W-1:0] sat_add(input logic signed [CELL_W-1:0] a,
                                                       input logic signed [CELL_W-1:0] b);
    logic signed [CELL_W:0] s;
    logic signed [CELL_W-1:0] r;
    begin
      s = {a[CELL_W-1], a} + {b[CELL_W-1], b};
      if (s[CELL_W] != s[CELL_W-1]) r = s[CELL_W] ? {1'b1, {(CELL_W-1){1'b0}}}
                                                  : {1'b0, {(CELL_W-1){1'b1}}};
      else r = s[CELL_W-1:0];
      return r;
    end
  endfunction

endpackage
`default_nettype wire

### hdl/grlu_stream_if.sv
// Valid/ready stream channel carrying one payload word per handshake.
// Payload type is a parameter; used with the words of grlu_pkg.
`default_nettype none
interface grlu_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hdl/grlu_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module grlu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hdl/grid_ray_logodds_update.sv
// Occupancy grid update along one ray. After reset the block sweeps the grid to zero,
// one cell per cycle, and takes no command meanwhile; configuration writes are taken in
// any cycle and belong between commands. A cast is accepted, runs 16 CORDIC iterations
// for the direction (skipped on axis angles), then per axis a setup, a 32-step reciprocal
// divide and a boundary multiply when its component is nonzero, or the setup alone when
// it is zero, then a read state and a write state per traversed cell and a final read
// state to end the walk, and a read and a write state per footprint cell, since each
// cell is a read-modify-write on the one grid RAM port pair. A read passes through a
// read state and a wait state. One command is in flight at a time; the result waits in
// an output register and the next command is taken once it has been delivered.
// Depends on grlu_pkg, grlu_stream_if and grlu_ram.
`default_nettype none
module grid_ray_logodds_update
  import grlu_pkg::*;
#(
  parameter int GRID_DIM  = GRID_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  grlu_stream_if.sink                in_chan,
  grlu_stream_if.source              out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int GRID_CELLS = GRID_DIM * GRID_DIM;
  localparam int AW = $clog2(GRID_CELLS);
  localparam int IW = $clog2(GRID_DIM);
  localparam int F_W = FRAC_BITS + 1;
  localparam int PROD_W = F_W + STEP_W;
  localparam int LIM_SH = 16 - FRAC_BITS;
  localparam logic signed [COORD_W-1:0] GRID_LIM = COORD_W'(GRID_DIM);
  localparam logic [AW-1:0] LAST_ADDR = AW'(GRID_CELLS - 1);
  localparam logic [F_W-1:0] FRAC_ONE = F_W'(1) << FRAC_BITS;

  state_t state_r, state_nxt;

  // configuration
  logic signed [CELL_W-1:0] free_inc_r, occ_inc_r;
  logic [1:0]               extent_r;

  // command context
  logic signed [COORD_W-1:0] cx_r, cy_r;
  logic [FRAC_BITS-1:0]      fracx_r, fracy_r;
  logic [DIST_W-1:0]         limit_r, trav_r, dxd_r, dyd_r, stx_r, sty_r;
  logic signed [COMP_W-1:0]  c_r, s_r;
  logic [COUNT_W-1:0]        count_r;
  logic                      axis_r;

  // CORDIC
  logic signed [CORD_W-1:0] x_r, y_r;
  logic signed [ANG_W-1:0]  z_r;
  logic [3:0]               iter_r;

  // divider
  logic [MAG_W-1:0]  mag_r;
  logic [MAG_W-1:0]  rem_r;
  logic [STEP_W-1:0] quo_r;
  logic [4:0]        div_cnt_r;

  // cell access
  logic [1:0]     fi_r, fj_r;
  logic           foot_last_r;
  logic           hit_r;
  logic [AW-1:0]  addr_r;
  logic [AW-1:0]  clr_addr_r;

  logic                   out_valid_r;
  out_word_t              out_word_r;

  // RAM controls
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [CELL_W-1:0]        ram_wdata, ram_rdata;

  in_word_t in_w;
  logic     in_acc;
  assign in_w = in_chan.payload;
  assign in_chan.ready = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.payload = out_word_r;

  // current cell position and its address
  logic signed [COORD_W-1:0] px, py;
  logic                      p_in;
  logic [AW-1:0]             p_addr;
  always_comb begin
    if (state_r == S_FOOT_RD) begin
      px = cx_r + $signed({{(COORD_W-2){1'b0}}, fi_r});
      py = cy_r + $signed({{(COORD_W-2){1'b0}}, fj_r});
    end else begin
      px = cx_r;
      py = cy_r;
    end
    p_in = !px[COORD_W-1] && !py[COORD_W-1] && (px < GRID_LIM) && (py < GRID_LIM);
    p_addr = AW'(py[IW-1:0]) * AW'(GRID_DIM) + AW'(px[IW-1:0]);
  end

  logic xs, ys, step_y, more;
  assign xs = (c_r != '0);
  assign ys = (s_r != '0);
  assign step_y = ys && (!xs || (dyd_r < dxd_r));
  assign more = trav_r < limit_r;

  // CORDIC shift-add unit
  logic signed [CORD_W-1:0] cx_sh, cy_sh;
  logic signed [ANG_W-1:0]  z_step;
  assign cx_sh = y_r >>> iter_r;
  assign cy_sh = x_r >>> iter_r;
  assign z_step = $signed({{(ANG_W-14){1'b0}}, atan_step(iter_r)});

  // divider bit step
  logic [MAG_W:0] rem_sh;
  logic           div_ge;
  assign rem_sh = {rem_r, (div_cnt_r == 5'd0)};
  assign div_ge = rem_sh >= {1'b0, mag_r};

  // boundary multiply
  logic signed [COMP_W-1:0] comp_sel;
  logic [FRAC_BITS-1:0]     frac_sel;
  logic [F_W-1:0]           f_sel;
  logic [PROD_W-1:0]        prod;
  assign comp_sel = axis_r ? s_r : c_r;
  assign frac_sel = axis_r ? fracy_r : fracx_r;
  assign f_sel = (!comp_sel[COMP_W-1] && comp_sel != '0) ? FRAC_ONE - F_W'(frac_sel)
                                                         : F_W'(frac_sel);
  assign prod = PROD_W'(f_sel) * PROD_W'(quo_r);

  logic [MAG_W-1:0] mag_sel;
  assign mag_sel = MAG_W'(comp_sel[COMP_W-1] ? -comp_sel : comp_sel);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:     if (clr_addr_r == LAST_ADDR) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (in_w.cmd == CMD_READ) state_nxt = S_READ_RD;
          else if (in_w.heading[13:0] == '0) state_nxt = S_PREP;
          else state_nxt = S_CORDIC;
        end
      end
      S_CORDIC:    if (iter_r == 4'(CORD_ITER - 1)) state_nxt = S_PREP;
      S_PREP: begin
        if (comp_sel != '0) state_nxt = S_DIV;
        else if (axis_r) state_nxt = S_WALK_RD;
      end
      S_DIV:       if (div_cnt_r == 5'd31) state_nxt = S_MUL;
      S_MUL:       state_nxt = axis_r ? S_WALK_RD : S_PREP;
      S_WALK_RD:   state_nxt = more ? S_WALK_WR : S_FOOT_RD;
      S_WALK_WR:   state_nxt = S_WALK_RD;
      S_FOOT_RD:   state_nxt = S_FOOT_WR;
      S_FOOT_WR:   state_nxt = foot_last_r ? S_IDLE : S_FOOT_RD;
      S_READ_RD:   state_nxt = S_READ_WAIT;
      S_READ_WAIT: state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    ram_raddr = p_addr;
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = sat_add(ram_rdata, free_inc_r);
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      S_WALK_WR: ram_we = hit_r;
      S_FOOT_WR: begin
        ram_we    = hit_r;
        ram_wdata = sat_add(ram_rdata, occ_inc_r);
      end
      default: ram_we = 1'b0;
    endcase
  end

  grlu_ram #(.WIDTH(CELL_W), .DEPTH(GRID_CELLS)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      free_inc_r  <= -16'sd102;
      occ_inc_r   <= 16'sd217;
      extent_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_FREE_INC: free_inc_r <= $signed(cfg_data);
          CFG_OCC_INC:  occ_inc_r  <= $signed(cfg_data);
          CFG_EXTENT:   extent_r   <= cfg_data[1:0];
          CFG_SPARE:    ;
        endcase
      end
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_FOOT_WR && foot_last_r) || state_r == S_READ_WAIT) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          trav_r  <= '0;
          dxd_r   <= '0;
          dyd_r   <= '0;
          stx_r   <= '0;
          sty_r   <= '0;
          count_r <= '0;
          axis_r  <= 1'b0;
          iter_r  <= '0;
          fracx_r <= in_w.start_x[FRAC_BITS-1:0];
          fracy_r <= in_w.start_y[FRAC_BITS-1:0];
          limit_r <= DIST_W'(in_w.ray_range) << LIM_SH;
          if (in_w.cmd == CMD_READ) begin
            cx_r <= $signed(COORD_W'(in_w.read_col));
            cy_r <= $signed(COORD_W'(in_w.read_row));
          end else begin
            cx_r <= $signed(COORD_W'(in_w.start_x >> FRAC_BITS));
            cy_r <= $signed(COORD_W'(in_w.start_y >> FRAC_BITS));
          end
          unique case (in_w.heading[15:14])
            2'd0: begin c_r <= UNIT_POS; s_r <= '0; end
            2'd1: begin c_r <= '0; s_r <= UNIT_POS; end
            2'd2: begin c_r <= UNIT_NEG; s_r <= '0; end
            2'd3: begin c_r <= '0; s_r <= UNIT_NEG; end
          endcase
          y_r <= '0;
          // fold angles beyond a quarter turn by a half turn
          if (in_w.heading[15] != in_w.heading[14] && in_w.heading[13:0] != '0) begin
            x_r <= -CORDIC_GAIN;
            z_r <= $signed({{(ANG_W-15){~in_w.heading[15]}}, in_w.heading[14:0]});
          end else begin
            x_r <= CORDIC_GAIN;
            z_r <= $signed({{(ANG_W-16){in_w.heading[15]}}, in_w.heading});
          end
        end
      end
      S_CORDIC: begin
        iter_r <= iter_r + 4'd1;
        if (!z_r[ANG_W-1]) begin
          x_r <= x_r - cx_sh;
          y_r <= y_r + cy_sh;
          z_r <= z_r - z_step;
        end else begin
          x_r <= x_r + cx_sh;
          y_r <= y_r - cy_sh;
          z_r <= z_r + z_step;
        end
        if (iter_r == 4'(CORD_ITER - 1)) begin
          c_r <= clamp_unit(!z_r[ANG_W-1] ? x_r - cx_sh : x_r + cx_sh);
          s_r <= clamp_unit(!z_r[ANG_W-1] ? y_r + cy_sh : y_r - cy_sh);
        end
      end
      S_PREP: begin
        mag_r     <= mag_sel;
        rem_r     <= '0;
        quo_r     <= '0;
        div_cnt_r <= '0;
        if (comp_sel == '0) begin
          axis_r <= 1'b1;
        end
      end
      S_DIV: begin
        div_cnt_r <= div_cnt_r + 5'd1;
        rem_r     <= MAG_W'(div_ge ? rem_sh - {1'b0, mag_r} : rem_sh);
        quo_r     <= {quo_r[STEP_W-2:0], div_ge};
      end
      S_MUL: begin
        if (axis_r) begin
          sty_r <= DIST_W'(quo_r);
          dyd_r <= DIST_W'(prod >> FRAC_BITS);
        end else begin
          stx_r <= DIST_W'(quo_r);
          dxd_r <= DIST_W'(prod >> FRAC_BITS);
        end
        axis_r <= 1'b1;
      end
      S_WALK_RD: begin
        hit_r  <= p_in;
        addr_r <= p_addr;
        fi_r   <= '0;
        fj_r   <= '0;
        if (more) begin
          if (step_y) begin
            cy_r   <= s_r[COMP_W-1] ? cy_r - COORD_W'(1) : cy_r + COORD_W'(1);
            trav_r <= dyd_r;
            dyd_r  <= dyd_r + sty_r;
          end else begin
            cx_r   <= c_r[COMP_W-1] ? cx_r - COORD_W'(1) : cx_r + COORD_W'(1);
            trav_r <= dxd_r;
            dxd_r  <= dxd_r + stx_r;
          end
        end
      end
      S_WALK_WR, S_FOOT_WR: begin
        if (hit_r && count_r != COUNT_MAX) begin
          count_r <= count_r + COUNT_W'(1);
        end
        if (state_r == S_FOOT_WR && foot_last_r) begin
          out_word_r.cell_value    <= '0;
          out_word_r.cells_touched <= (hit_r && count_r != COUNT_MAX)
                                      ? count_r + COUNT_W'(1) : count_r;
        end
      end
      S_FOOT_RD: begin
        hit_r       <= p_in;
        addr_r      <= p_addr;
        foot_last_r <= (fi_r == extent_r) && (fj_r == extent_r);
        // advance across the row, then to the next row
        if (fi_r == extent_r) begin
          fi_r <= '0;
          fj_r <= fj_r + 2'd1;
        end else begin
          fi_r <= fi_r + 2'd1;
        end
      end
      S_READ_RD: begin
        hit_r <= p_in;
      end
      S_READ_WAIT: begin
        out_word_r.cell_value    <= hit_r ? $signed(ram_rdata) : '0;
        out_word_r.cells_touched <= '0;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
